[design/assert_macros.svh]
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

[design/spa_pkg.sv]
package spa_pkg;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_FETCH,
        ST_CMP
    } spa_state_t;

    typedef enum logic [1:0]
    {
        MODE_LOAD_A = 2'd0,
        MODE_LOAD_B = 2'd1,
        MODE_RUN    = 2'd2,
        MODE_NOP    = 2'd3
    } spa_mode_t;

endpackage

[design/spa_ram.sv]
module spa_ram #(
    parameter int WIDTH  = 24,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/sparse_polynomial_adder.sv]
// Channel  Dir  Handshake           Payload
// s_       in   s_tvalid/s_tready   s_tuser = mode, s_tdata = coeff_in, expo_in
// m_       out  m_tvalid/m_tready   m_tdata = coeff_out, expo_out, m_tlast = last,
//                                   m_tuser = empty_res, overflow
//
// A run reads the two term RAMs, whose read is registered, and then compares and
// emits, once per result term; an empty run still emits one term. The term RAMs need
// no clearing after reset; only the control registers (state, counts, read indexes,
// drop flag, output valid) reset. A stalled output holds the merge in the compare
// step with its read data; loads are taken only between runs.
`include "assert_macros.svh"

module sparse_polynomial_adder #(
    parameter int TERMS_PER_LIST = 16,
    parameter int COEFF_BITS     = 16,
    parameter int EXPO_BITS      = 8
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  s_tvalid,
    output logic                                                  s_tready,
    // [COEFF_BITS-1:0] coeff_in, then expo_in, zero padded to bytes
    input  logic [((COEFF_BITS + EXPO_BITS + 7) / 8) * 8 - 1:0]   s_tdata,
    // [1:0] mode
    input  logic [1:0]                                            s_tuser,
    output logic                                                  m_tvalid,
    input  logic                                                  m_tready,
    // [COEFF_BITS:0] coeff_out, then expo_out, zero padded to bytes
    output logic [((COEFF_BITS + 1 + EXPO_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    output logic                                                  m_tlast,
    // [0] empty_res, [1] overflow
    output logic [1:0]                                            m_tuser
);

    import spa_pkg::*;

    localparam int TERM_W = COEFF_BITS + EXPO_BITS;
    localparam int OUT_DW = ((COEFF_BITS + 1 + EXPO_BITS + 7) / 8) * 8;
    localparam int CNT_W  = $clog2(TERMS_PER_LIST + 1);
    localparam int IDX_W  = (TERMS_PER_LIST > 1) ? $clog2(TERMS_PER_LIST) : 1;
    localparam logic [CNT_W-1:0] FULL = CNT_W'(TERMS_PER_LIST);

    spa_state_t state_reg, state_next;

    logic [CNT_W-1:0] first_cnt_reg, second_cnt_reg;
    logic [CNT_W-1:0] a_reg, b_reg, a_next, b_next;
    logic             dropped_reg;

    logic                        out_valid_reg;
    logic signed [COEFF_BITS:0]  coeff_out_reg;
    logic [EXPO_BITS-1:0]        expo_out_reg;
    logic                        last_out_reg;
    logic                        empty_out_reg;
    logic                        ovf_out_reg;

    logic        in_fire;
    logic        emit_en;
    spa_mode_t   mode;
    logic        we_a, we_b;
    logic [TERM_W-1:0] rd_a, rd_b;

    logic                       a_has, b_has, take_a, take_b;
    logic [EXPO_BITS-1:0]       ea, eb;
    logic signed [COEFF_BITS:0] ca_x, cb_x;
    logic signed [COEFF_BITS:0] coeff_sel;
    logic [EXPO_BITS-1:0]       expo_sel;
    logic                       last_sel;

    assign mode    = spa_mode_t'(s_tuser);
    assign in_fire = s_tvalid && s_tready;
    assign we_a    = in_fire && (mode == MODE_LOAD_A) && (first_cnt_reg < FULL);
    assign we_b    = in_fire && (mode == MODE_LOAD_B) && (second_cnt_reg < FULL);

    spa_ram #(
        .WIDTH (TERM_W),
        .DEPTH (TERMS_PER_LIST)
    ) u_ram_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (first_cnt_reg[IDX_W-1:0]),
        .wdata (s_tdata[TERM_W-1:0]),
        .raddr (a_reg[IDX_W-1:0]),
        .rdata (rd_a)
    );

    spa_ram #(
        .WIDTH (TERM_W),
        .DEPTH (TERMS_PER_LIST)
    ) u_ram_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (second_cnt_reg[IDX_W-1:0]),
        .wdata (s_tdata[TERM_W-1:0]),
        .raddr (b_reg[IDX_W-1:0]),
        .rdata (rd_b)
    );

    // Merge step on the two list heads
    always_comb
    begin
        a_has = a_reg < first_cnt_reg;
        b_has = b_reg < second_cnt_reg;
        ea    = rd_a[TERM_W-1:COEFF_BITS];
        eb    = rd_b[TERM_W-1:COEFF_BITS];
        ca_x  = signed'({rd_a[COEFF_BITS-1], rd_a[COEFF_BITS-1:0]});
        cb_x  = signed'({rd_b[COEFF_BITS-1], rd_b[COEFF_BITS-1:0]});
        if (a_has && b_has)
        begin
            take_a = (ea >= eb);
            take_b = (eb >= ea);
        end
        else
        begin
            take_a = a_has;
            take_b = b_has;
        end
        case ({take_a, take_b})
            2'b11:   coeff_sel = ca_x + cb_x;
            2'b10:   coeff_sel = ca_x;
            2'b01:   coeff_sel = cb_x;
            default: coeff_sel = '0;
        endcase
        expo_sel = take_a ? ea : (take_b ? eb : '0);
        a_next   = a_reg + CNT_W'(take_a);
        b_next   = b_reg + CNT_W'(take_b);
        last_sel = (a_next >= first_cnt_reg) && (b_next >= second_cnt_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (mode == MODE_RUN))
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (emit_en)
                begin
                    state_next = last_sel ? ST_IDLE : ST_FETCH;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        emit_en  = 1'b0;
        case (state_reg)
            ST_IDLE:  s_tready = 1'b1;
            ST_CMP:   emit_en  = !out_valid_reg || m_tready;
            default:
            begin
                s_tready = 1'b0;
                emit_en  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            first_cnt_reg  <= '0;
            second_cnt_reg <= '0;
            a_reg          <= '0;
            b_reg          <= '0;
            dropped_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (we_a)
            begin
                first_cnt_reg <= first_cnt_reg + 1'b1;
            end
            if (we_b)
            begin
                second_cnt_reg <= second_cnt_reg + 1'b1;
            end
            if (in_fire && (mode inside {MODE_LOAD_A, MODE_LOAD_B}) && !we_a && !we_b)
            begin
                dropped_reg <= 1'b1;
            end
            if (in_fire && (mode == MODE_RUN))
            begin
                a_reg <= '0;
                b_reg <= '0;
            end
            if (emit_en)
            begin
                if (last_sel)
                begin
                    // run done: clear the lists, the read indexes and the drop flag
                    a_reg          <= '0;
                    b_reg          <= '0;
                    first_cnt_reg  <= '0;
                    second_cnt_reg <= '0;
                    dropped_reg    <= 1'b0;
                end
                else
                begin
                    a_reg <= a_next;
                    b_reg <= b_next;
                end
            end
            if (emit_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_en)
        begin
            coeff_out_reg <= coeff_sel;
            expo_out_reg  <= expo_sel;
            last_out_reg  <= last_sel;
            empty_out_reg <= !take_a && !take_b;
            ovf_out_reg   <= dropped_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DW'({expo_out_reg, coeff_out_reg});
    assign m_tlast  = last_out_reg;
    assign m_tuser  = {ovf_out_reg, empty_out_reg};

    `ASSERT_NEVER(a_within_count, clk, rst_n, a_reg > first_cnt_reg,
                  "first list read index past its count")
    `ASSERT_NEVER(count_within_depth, clk, rst_n,
                  (first_cnt_reg > FULL) || (second_cnt_reg > FULL),
                  "term count beyond list depth")
    `ASSERT_PROP(emit_loads_output, clk, rst_n, emit_en |=> out_valid_reg,
                 "emitted term not presented")
    `ASSERT_PROP(stall_holds_merge, clk, rst_n,
                 (state_reg == ST_CMP) && out_valid_reg && !m_tready |=> state_reg == ST_CMP,
                 "merge advanced under output stall")
    `ASSERT_PROP(last_clears_lists, clk, rst_n,
                 emit_en && last_sel |=> (first_cnt_reg == '0) && (second_cnt_reg == '0),
                 "lists not cleared after run")

endmodule

[tb/sparse_polynomial_adder_tb.sv]
module sparse_polynomial_adder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spa_pkg::*;

    localparam int TERMS       = 16;
    localparam int STUCK_LIMIT = 2000;
    localparam int HOLD_CYCLES = 400;
    localparam int STIM_TARGET = 320;

    typedef struct packed
    {
        spa_mode_t   mode;
        logic [15:0] coeff;
        logic [7:0]  expo;
    } term_item_t;

    typedef struct packed
    {
        logic signed [16:0] coeff;
        logic [7:0]         expo;
        logic               last;
        logic               empty;
        logic               ovf;
    } sum_term_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;

    // Predictor state: two term lists, their counts and the sticky drop flag
    logic signed [15:0] list_coeff [2][TERMS];
    logic [7:0]         list_expo  [2][TERMS];
    int unsigned        list_count [2];
    bit                 dropped;

    term_item_t term_items_q [$];
    sum_term_t  sum_terms_q [$];
    term_item_t next_item;
    sum_term_t  want;
    sum_term_t  got;

    int  stim_count;
    int  total_items;
    int  items_driven;
    int  items_taken;
    int  results_checked;
    int  err_count;
    int  stuck_cycles;
    int  send_gap;
    int  ready_gap;
    int  hold_left;
    int  runs_seen;
    int  drops_seen;
    int  zero_sums;
    int  ovf_results;
    bit  hold_done;
    bit  item_taken;
    bit  result_taken;
    bit  progress;

    sparse_polynomial_adder #(
        .TERMS_PER_LIST (TERMS),
        .COEFF_BITS     (16),
        .EXPO_BITS      (8)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #10 clk = ~clk;

    task automatic predict_term_item(spa_mode_t mode, logic signed [15:0] coeff,
                                     logic [7:0] expo);
        int unsigned        sel;
        int unsigned        ia;
        int unsigned        ib;
        logic signed [16:0] ca;
        logic signed [16:0] cb;
        sum_term_t          t;
        case (mode)
            MODE_LOAD_A, MODE_LOAD_B:
            begin
                sel = (mode == MODE_LOAD_B) ? 1 : 0;
                if (list_count[sel] >= TERMS)
                begin
                    dropped = 1'b1;
                    drops_seen++;
                end
                else
                begin
                    list_coeff[sel][list_count[sel]] = coeff;
                    list_expo[sel][list_count[sel]]  = expo;
                    list_count[sel]++;
                end
            end
            MODE_RUN:
            begin
                runs_seen++;
                ia = 0;
                ib = 0;
                if (list_count[0] == 0 && list_count[1] == 0)
                    sum_terms_q.push_back('{17'sd0, 8'd0, 1'b1, 1'b1, dropped});
                while (ia < list_count[0] || ib < list_count[1])
                begin
                    if (ia < list_count[0] && ib < list_count[1]
                        && list_expo[0][ia] == list_expo[1][ib])
                    begin
                        ca      = list_coeff[0][ia];
                        cb      = list_coeff[1][ib];
                        t.coeff = ca + cb;
                        t.expo  = list_expo[0][ia];
                        ia++;
                        ib++;
                        if (t.coeff == 0)
                            zero_sums++;
                    end
                    else if (ib >= list_count[1]
                             || (ia < list_count[0] && list_expo[0][ia] > list_expo[1][ib]))
                    begin
                        ca      = list_coeff[0][ia];
                        t.coeff = ca;
                        t.expo  = list_expo[0][ia];
                        ia++;
                    end
                    else
                    begin
                        cb      = list_coeff[1][ib];
                        t.coeff = cb;
                        t.expo  = list_expo[1][ib];
                        ib++;
                    end
                    t.last  = (ia >= list_count[0] && ib >= list_count[1]);
                    t.empty = 1'b0;
                    t.ovf   = dropped;
                    sum_terms_q.push_back(t);
                end
                list_count[0] = 0;
                list_count[1] = 0;
                dropped       = 1'b0;
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic queue_item(spa_mode_t mode, logic [15:0] coeff, logic [7:0] expo);
        term_items_q.push_back('{mode, coeff, expo});
        if (mode != MODE_NOP)
            stim_count++;
    endtask

    // Build two polynomials over a shared exponent walk, descending unless scrambled, so many
    // exponents line up, then interleave their loads and close with a run.
    task automatic queue_poly_pair(bit fill);
        term_item_t  a_q [$];
        term_item_t  b_q [$];
        term_item_t  it;
        int          slots;
        int          e;
        int          k;
        bit [1:0]    owner;
        bit          scramble;
        logic [15:0] c;
        if (fill)
            slots = 2 * TERMS + 2;
        else if ($urandom_range(0, 7) == 0)
            slots = $urandom_range(12, 24);
        else
            slots = $urandom_range(0, 10);
        scramble = !fill && ($urandom_range(0, 9) == 0);
        e = fill ? 255 : $urandom_range(0, 255);
        for (k = 0; k < slots && e >= 0; k++)
        begin
            owner = fill ? ((k % 2 == 1) ? 2'b10 : 2'b01) : 2'($urandom_range(1, 3));
            case ($urandom_range(0, 9))
                0: c = 16'h7fff;
                1: c = 16'h8000;
                default: c = 16'($urandom);
            endcase
            if (owner[0])
                a_q.push_back('{MODE_LOAD_A, c, 8'(e)});
            if (owner[1])
            begin
                // cancel the first list's term now and then
                if ($urandom_range(0, 3) == 0)
                    b_q.push_back('{MODE_LOAD_B, -c, 8'(e)});
                else
                    b_q.push_back('{MODE_LOAD_B, 16'($urandom), 8'(e)});
            end
            if (scramble)
                e = $urandom_range(0, 255);
            else
                e = e - (fill ? 1 : $urandom_range(1, 12));
        end
        while (a_q.size() > 0 || b_q.size() > 0)
        begin
            if (b_q.size() == 0 || (a_q.size() > 0 && $urandom_range(0, 1) == 1))
                it = a_q.pop_front();
            else
                it = b_q.pop_front();
            queue_item(it.mode, it.coeff, it.expo);
            if ($urandom_range(0, 15) == 0)
                queue_item(MODE_NOP, 16'($urandom), 8'($urandom));
        end
        queue_item(MODE_RUN, 16'($urandom), 8'($urandom));
    endtask

    // Sender: hold the item until taken, then wait the drawn gap
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || item_taken))
        begin
            item_taken = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (term_items_q.size() > 0)
            begin
                next_item = term_items_q.pop_front();
                s_tuser  <= next_item.mode;
                s_tdata  <= {next_item.expo, next_item.coeff};
                s_tvalid <= 1'b1;
                send_gap  = ((items_driven / 48) % 3 == 1) ? 0 : $urandom_range(0, 8);
                items_driven++;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: random stall after each result outside the no-stall phases, plus one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (result_taken)
            begin
                result_taken = 1'b0;
                ready_gap = ((results_checked / 40) % 3 == 2) ? 0 : $urandom_range(0, 8);
                if (!hold_done && results_checked >= 40)
                begin
                    hold_done = 1'b1;
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (ready_gap > 0)
            begin
                ready_gap--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Monitor: predict on accepted input, check accepted results, watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            progress = 1'b0;
            if (s_tvalid && s_tready)
            begin
                predict_term_item(spa_mode_t'(s_tuser), s_tdata[15:0], s_tdata[23:16]);
                item_taken = 1'b1;
                items_taken++;
                progress = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                got.coeff = m_tdata[16:0];
                got.expo  = m_tdata[24:17];
                got.last  = m_tlast;
                got.empty = m_tuser[0];
                got.ovf   = m_tuser[1];
                if (got.ovf === 1'b1)
                    ovf_results++;
                if (sum_terms_q.size() == 0)
                begin
                    if (err_count < 10)
                        $display("unexpected result: coeff %0d expo %0d last %0b empty %0b ovf %0b",
                                 $signed(got.coeff), got.expo, got.last, got.empty, got.ovf);
                    err_count++;
                end
                else
                begin
                    want = sum_terms_q.pop_front();
                    if (got !== want)
                    begin
                        if (err_count < 10)
                            $display({"mismatch at result %0d: expected coeff %0d expo %0d last %0b",
                                      " empty %0b ovf %0b, got coeff %0d expo %0d last %0b",
                                      " empty %0b ovf %0b"},
                                     results_checked, $signed(want.coeff), want.expo, want.last,
                                     want.empty, want.ovf, $signed(got.coeff), got.expo,
                                     got.last, got.empty, got.ovf);
                        err_count++;
                    end
                end
                results_checked++;
                result_taken = 1'b1;
                progress = 1'b1;
            end
            if (progress)
                stuck_cycles = 0;
            else
            begin
                stuck_cycles++;
                if (stuck_cycles >= STUCK_LIMIT)
                begin
                    $display("timeout: no item moved for %0d cycles, %0d results outstanding",
                             STUCK_LIMIT, sum_terms_q.size());
                    $display("sparse_polynomial_adder test failed");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        clk      = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = MODE_NOP;
        m_tready = 1'b0;
        list_count[0] = 0;
        list_count[1] = 0;
        dropped = 1'b0;

        // empty run, then an ignored item
        queue_item(MODE_RUN, 16'h0000, 8'h00);
        queue_item(MODE_NOP, 16'hffff, 8'hff);
        // extreme coefficients on matching exponents at both ends of the range
        queue_item(MODE_LOAD_A, 16'h7fff, 8'hff);
        queue_item(MODE_LOAD_A, 16'h8000, 8'h00);
        queue_item(MODE_LOAD_B, 16'h7fff, 8'hff);
        queue_item(MODE_LOAD_B, 16'h8000, 8'h00);
        queue_item(MODE_RUN, 16'hffff, 8'hff);
        // zero sum is kept, then the first list's tail is copied
        queue_item(MODE_LOAD_A, 16'd5, 8'd10);
        queue_item(MODE_LOAD_B, -16'sd5, 8'd10);
        queue_item(MODE_LOAD_A, 16'd1, 8'd3);
        queue_item(MODE_RUN, 16'h0000, 8'h00);
        // second list only
        queue_item(MODE_LOAD_B, 16'd7, 8'd200);
        queue_item(MODE_LOAD_B, 16'hffff, 8'd100);
        queue_item(MODE_RUN, 16'h0000, 8'h00);
        // first list loaded out of order
        queue_item(MODE_LOAD_A, 16'd11, 8'd1);
        queue_item(MODE_LOAD_A, 16'd12, 8'd50);
        queue_item(MODE_LOAD_B, 16'd13, 8'd30);
        queue_item(MODE_LOAD_B, 16'd14, 8'd2);
        queue_item(MODE_RUN, 16'h0000, 8'h00);
        // single zero term
        queue_item(MODE_LOAD_A, 16'd0, 8'd0);
        queue_item(MODE_RUN, 16'h0000, 8'h00);

        // both lists overrun with distinct exponents: most results per run
        queue_poly_pair(1'b1);
        while (stim_count < STIM_TARGET)
            queue_poly_pair($urandom_range(0, 11) == 0);
        total_items = term_items_q.size();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (items_taken < total_items || sum_terms_q.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);

        $display("covered %0d items, %0d runs, %0d result terms checked", items_taken,
                 runs_seen, results_checked);
        $display("%0d loads dropped on full lists, %0d results flagged overflow, %0d zero sums",
                 drops_seen, ovf_results, zero_sums);
        if (err_count == 0 && sum_terms_q.size() == 0)
            $display("sparse_polynomial_adder test passed");
        else
            $display("sparse_polynomial_adder test failed");
        $finish;
    end

endmodule
